// ----- design/sai_pkg.sv -----
// ----------------------------------------------------------------------------
// sai_pkg
// Shared types and codes of the safety arming interlock: request and response
// payloads, request kinds, modes, status codes, reason codes and defaults.
// ----------------------------------------------------------------------------
package sai_pkg;

  // default widths of the internal counters
  localparam int unsigned GenWidthDef   = 32;
  localparam int unsigned FreshWidthDef = 8;

  // configuration port
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 32;

  // request kinds
  typedef enum logic [2:0] {
    REQ_BOOT    = 3'd0,
    REQ_OBSERVE = 3'd1,
    REQ_ARM     = 3'd2,
    REQ_DISARM  = 3'd3,
    REQ_ESTOP   = 3'd4,
    REQ_RESET   = 3'd5
  } req_e;

  // operating modes
  typedef enum logic [2:0] {
    MODE_BOOT_INH  = 3'd0,
    MODE_RECOV_INH = 3'd1,
    MODE_FAULT_INH = 3'd2,
    MODE_DISARMED  = 3'd3,
    MODE_ARMED     = 3'd4,
    MODE_LATCHED   = 3'd5
  } mode_e;

  // response status codes
  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_BAD_TIME     = 4'd1,
    ST_ACT_OFF      = 4'd2,
    ST_GEN_MISMATCH = 4'd3,
    ST_NOT_READY    = 4'd4,
    ST_NO_OPERATOR  = 4'd5,
    ST_LATCHED      = 4'd6,
    ST_BAD_ESTOP    = 4'd7,
    ST_AUTH_REJECT  = 4'd8,
    ST_RESET_BAD    = 4'd9,
    ST_NOT_CLEARED  = 4'd10
  } status_e;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_FRESH_COUNT  = 2'd0,
    CFG_VALID_WINDOW = 2'd1,
    CFG_ACT_ENABLE   = 2'd2,
    CFG_RESET_ENABLE = 2'd3
  } cfg_idx_e;

  // reason codes; faults reported by the caller occupy the upper codes
  localparam logic [3:0] RSN_NONE     = 4'd0;
  localparam logic [3:0] RSN_INVALID  = 4'd1;
  localparam logic [3:0] RSN_RECOVERY = 4'd2;
  localparam logic [3:0] RSN_DISARMED = 4'd3;
  localparam logic [3:0] RSN_ESTOP    = 4'd4;

  // configuration reset values
  localparam logic [7:0]  FreshCountRst  = 8'd3;
  localparam logic [31:0] ValidWindowRst = 32'd100000000;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [63:0] timestamp;
    logic               all_clear;
    logic [3:0]         reported_reason;
    logic               operator_present;
    logic [31:0]        expected_generation;
    logic               estop_asserted;
    logic               estop_stamp_positive;
    logic               estop_ids_present;
    logic               auth_granted;
    logic               clear_acknowledged;
  } req_t;

  typedef struct packed {
    logic               accepted;
    status_e            status_code;
    mode_e              mode_out;
    logic [3:0]         reason_out;
    logic [31:0]        state_generation;
    logic [31:0]        latch_count;
    logic               state_valid;
    logic [31:0]        valid_for;
    logic signed [63:0] stamp_out;
  } rsp_t;

endpackage

// ----- design/sai_req_if.sv -----
// ----------------------------------------------------------------------------
// sai_req_if
// Request channel: valid/ready handshake carrying one interlock request.
// ----------------------------------------------------------------------------
interface sai_req_if;
  import sai_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/sai_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sai_rsp_if
// Response channel: valid/ready handshake carrying one interlock result.
// ----------------------------------------------------------------------------
interface sai_rsp_if;
  import sai_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/safety_arming_interlock.sv -----
// ----------------------------------------------------------------------------
// safety_arming_interlock
// Arming interlock that tracks boot, observed conditions, arming and
// emergency stop latching, and answers each request with its verdict and a
// snapshot of the resulting state.
// ----------------------------------------------------------------------------
//
// channel  | dir | payload | transaction
// ---------+-----+---------+------------------------------------------------
// req_i    | in  | req_t   | one request (boot/observe/arm/disarm/estop/reset)
// rsp_o    | out | rsp_t   | one result per request, in request order
// cfg      | in  | 32 bit  | register write when cfg_we_i is high
//
// - one request per cycle sustained while responses are taken; a request
//   passes the input register, then the response register, before its
//   response is valid
// - the state update sits between the input register and the response
//   register, so each request sees the state left by the one before it
// - reset clears mode, reason, counters and flags and loads the register
//   defaults; no clearing pass
// - a stalled response holds the response register and the input register;
//   the request channel stays ready while the input register can drain
// ----------------------------------------------------------------------------
module safety_arming_interlock #(
  parameter int unsigned GEN_WIDTH   = sai_pkg::GenWidthDef,
  parameter int unsigned FRESH_WIDTH = sai_pkg::FreshWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sai_req_if.sink                             req_i,
  sai_rsp_if.source                           rsp_o,
  input  logic                                cfg_we_i,
  input  logic [sai_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [sai_pkg::CfgDataWidth-1:0]    cfg_wdata_i
);
  import sai_pkg::*;

  // configuration registers
  logic [7:0]  fresh_cnt_q;
  logic [31:0] valid_win_q;
  logic        act_en_q;
  logic        rst_en_q;

  // interlock state
  mode_e                  mode_q, mode_d;
  logic [3:0]             rsn_q, rsn_d;
  logic [GEN_WIDTH-1:0]   st_gen_q, st_gen_d;
  logic [GEN_WIDTH-1:0]   latch_q, latch_d;
  logic [FRESH_WIDTH-1:0] cnt_q, cnt_d;
  logic                   boot_q, boot_d;
  logic                   clr_q, clr_d;

  // pipeline registers
  logic s1_valid_q;
  req_t s1_q;
  logic rsp_valid_q;
  rsp_t rsp_q, rsp_d;

  logic advance;
  logic fire;

  // handshake: response register drains or is empty, input register follows
  assign advance     = !rsp_valid_q || rsp_o.ready;
  assign fire        = s1_valid_q && advance;
  assign req_i.ready = !s1_valid_q || advance;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_cnt_q <= FreshCountRst;
      valid_win_q <= ValidWindowRst;
      act_en_q    <= 1'b0;
      rst_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRESH_COUNT:  fresh_cnt_q <= cfg_wdata_i[7:0];
        CFG_VALID_WINDOW: valid_win_q <= cfg_wdata_i;
        CFG_ACT_ENABLE:   act_en_q    <= cfg_wdata_i[0];
        CFG_RESET_ENABLE: rst_en_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // request fields and derived checks
  logic                     ts_ok;
  logic                     cfg_ok;
  logic [GEN_WIDTH+31:0]    st_gen_ext;
  logic [GEN_WIDTH+31:0]    latch_ext;
  logic [31:0]              st_gen32;
  logic [31:0]              latch32;
  logic [FRESH_WIDTH+7:0]   cnt_ext;
  logic [FRESH_WIDTH+7:0]   cnt_up_ext;
  logic [FRESH_WIDTH+7:0]   need_ext;
  logic [FRESH_WIDTH-1:0]   cnt_up;
  logic                     full_q;
  logic                     full_up;
  logic                     is_latched;

  assign ts_ok      = !s1_q.timestamp[63] && (s1_q.timestamp != 64'sd0);
  assign cfg_ok     = (fresh_cnt_q != 8'd0) && (valid_win_q != 32'd0);
  assign st_gen_ext = {32'd0, st_gen_q};
  assign latch_ext  = {32'd0, latch_q};
  assign st_gen32   = st_gen_ext[31:0];
  assign latch32    = latch_ext[31:0];
  assign is_latched = (mode_q == MODE_LATCHED);

  // clear-observation counter: saturates at the threshold and at all ones
  assign cnt_up     = (!full_q && (cnt_q != {FRESH_WIDTH{1'b1}})) ?
                      cnt_q + {{(FRESH_WIDTH-1){1'b0}}, 1'b1} : cnt_q;
  assign need_ext   = {{FRESH_WIDTH{1'b0}}, fresh_cnt_q};
  assign cnt_ext    = {8'd0, cnt_q};
  assign cnt_up_ext = {8'd0, cnt_up};
  assign full_q     = (cnt_ext >= need_ext);
  assign full_up    = (cnt_up_ext >= need_ext);

  // request evaluation and next state
  logic    acc;
  status_e st;
  logic    force_bump;

  always_comb begin
    mode_d     = mode_q;
    rsn_d      = rsn_q;
    latch_d    = latch_q;
    cnt_d      = cnt_q;
    boot_d     = boot_q;
    clr_d      = clr_q;
    acc        = 1'b0;
    st         = ST_OK;
    force_bump = 1'b0;
    unique case (req_e'(s1_q.req_type))
      REQ_BOOT: begin
        acc = 1'b1;
        if (!is_latched && !boot_q) begin
          if (!cfg_ok || !ts_ok) begin
            mode_d = MODE_BOOT_INH;
            rsn_d  = RSN_INVALID;
          end else begin
            boot_d = 1'b1;
            cnt_d  = '0;
            clr_d  = 1'b0;
            mode_d = MODE_RECOV_INH;
            rsn_d  = RSN_RECOVERY;
          end
        end
      end
      REQ_OBSERVE: begin
        acc = 1'b1;
        if (!boot_q || !ts_ok) begin
          cnt_d = '0;
          clr_d = 1'b0;
          if (!is_latched) begin
            mode_d = MODE_BOOT_INH;
            rsn_d  = RSN_INVALID;
          end
        end else if (!s1_q.all_clear) begin
          clr_d = 1'b0;
          cnt_d = '0;
          if (!is_latched) begin
            mode_d = MODE_FAULT_INH;
            rsn_d  = (s1_q.reported_reason == RSN_NONE) ? RSN_INVALID
                                                        : s1_q.reported_reason;
          end
        end else begin
          clr_d = 1'b1;
          cnt_d = cnt_up;
          if (!is_latched) begin
            if (!full_up) begin
              mode_d = MODE_RECOV_INH;
              rsn_d  = RSN_RECOVERY;
            end else if (mode_q != MODE_ARMED) begin
              mode_d = MODE_DISARMED;
              rsn_d  = RSN_DISARMED;
            end
          end
        end
      end
      REQ_ARM: begin
        priority if (!ts_ok) begin
          st = ST_BAD_TIME;
        end else if (!act_en_q) begin
          st = ST_ACT_OFF;
        end else if (!s1_q.operator_present || (s1_q.expected_generation != st_gen32)) begin
          st = ST_GEN_MISMATCH;
        end else if (!boot_q || !clr_q || !full_q || (mode_q != MODE_DISARMED)) begin
          st = ST_NOT_READY;
        end else begin
          mode_d = MODE_ARMED;
          rsn_d  = RSN_NONE;
          acc    = 1'b1;
        end
      end
      REQ_DISARM: begin
        priority if (!s1_q.operator_present) begin
          st = ST_NO_OPERATOR;
        end else if (is_latched) begin
          st = ST_LATCHED;
        end else begin
          mode_d = MODE_DISARMED;
          rsn_d  = RSN_DISARMED;
          acc    = 1'b1;
        end
      end
      REQ_ESTOP: begin
        if (!s1_q.estop_asserted || !s1_q.estop_stamp_positive ||
            !s1_q.estop_ids_present) begin
          st = ST_BAD_ESTOP;
        end else begin
          latch_d    = latch_q + {{(GEN_WIDTH-1){1'b0}}, 1'b1};
          force_bump = 1'b1;
          cnt_d      = '0;
          clr_d      = 1'b0;
          mode_d     = MODE_LATCHED;
          rsn_d      = RSN_ESTOP;
          acc        = 1'b1;
        end
      end
      REQ_RESET: begin
        priority if (!ts_ok) begin
          st = ST_BAD_TIME;
        end else if (!rst_en_q || !s1_q.auth_granted) begin
          st = ST_AUTH_REJECT;
        end else if (!s1_q.operator_present || !s1_q.clear_acknowledged ||
                     (s1_q.expected_generation != latch32)) begin
          st = ST_RESET_BAD;
        end else if (!is_latched || !clr_q || !full_q) begin
          st = ST_NOT_CLEARED;
        end else begin
          mode_d = MODE_DISARMED;
          rsn_d  = RSN_DISARMED;
          acc    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state generation bumps on any mode or reason change, and on every accepted estop
  assign st_gen_d = (force_bump || (mode_d != mode_q) || (rsn_d != rsn_q)) ?
                    st_gen_q + {{(GEN_WIDTH-1){1'b0}}, 1'b1} : st_gen_q;

  // response assembly from the updated state
  logic [GEN_WIDTH+31:0] st_gen_d_ext;
  logic [GEN_WIDTH+31:0] latch_d_ext;

  assign st_gen_d_ext = {32'd0, st_gen_d};
  assign latch_d_ext  = {32'd0, latch_d};

  always_comb begin
    rsp_d.accepted         = acc;
    rsp_d.status_code      = st;
    rsp_d.mode_out         = mode_d;
    rsp_d.reason_out       = rsn_d;
    rsp_d.state_generation = st_gen_d_ext[31:0];
    rsp_d.latch_count      = latch_d_ext[31:0];
    rsp_d.state_valid      = cfg_ok && ts_ok;
    rsp_d.valid_for        = valid_win_q;
    rsp_d.stamp_out        = s1_q.timestamp;
  end

  // control state and interlock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      mode_q      <= MODE_BOOT_INH;
      rsn_q       <= RSN_NONE;
      st_gen_q    <= '0;
      latch_q     <= '0;
      cnt_q       <= '0;
      boot_q      <= 1'b0;
      clr_q       <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (advance) begin
        rsp_valid_q <= s1_valid_q;
      end
      if (fire) begin
        mode_q   <= mode_d;
        rsn_q    <= rsn_d;
        st_gen_q <= st_gen_d;
        latch_q  <= latch_d;
        cnt_q    <= cnt_d;
        boot_q   <= boot_d;
        clr_q    <= clr_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_q <= req_i.data;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

`ifndef ASSERT_OFF
  // armed mode is reachable only after a completed boot
  a_armed_needs_boot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_ARMED) |-> boot_q)
    else $error("armed without completed boot");

  // the latch generation moves only together with entering the latched mode
  a_latch_bump_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (latch_d != latch_q)) |=> (mode_q == MODE_LATCHED))
    else $error("latch generation moved without latching");

  // a mode change is always visible as a new state generation
  a_mode_change_bumps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (mode_d != mode_q)) |=> (st_gen_q != $past(st_gen_q)))
    else $error("mode changed without a generation bump");

  // an accepted response never carries a failure status
  a_accept_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.accepted) |-> (rsp_q.status_code == ST_OK))
    else $error("accepted response with failure status");

  // a request held in the input register is not dropped while stalled
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("stalled request lost");
`endif

endmodule
